[design/rrbct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rrbct_pkg;

    // count fields: run pixels, blob widths and blob rows
    localparam int CNT_BITS = 12;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    // gap counter saturates at the top of its range
    localparam int GAP_BITS = 8;
    localparam logic [GAP_BITS-1:0] GAP_MAX = '1;

    localparam int LW_BITS = 12;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH = 2'd1;
    localparam logic [GAP_BITS-1:0]     GAP_RESET      = 8'd50;
    localparam logic [LW_BITS-1:0]      LW_RESET       = 12'd640;

    // a merge folds the second blob in with one-third weight
    localparam logic [CNT_BITS-1:0] MERGE_K = 12'd2;

    typedef enum logic [1:0] {
        STATUS_JOIN = 2'd0,
        STATUS_NEW  = 2'd1,
        STATUS_DROP = 2'd2
    } status_t;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_RUNDIV   = 12'b0000_0000_0010,
        S_SCAN_RD  = 12'b0000_0000_0100,
        S_SCAN_CHK = 12'b0000_0000_1000,
        S_MERGE_X  = 12'b0000_0001_0000,
        S_MERGE_Y  = 12'b0000_0010_0000,
        S_CMP_RD   = 12'b0000_0100_0000,
        S_CMP_WR   = 12'b0000_1000_0000,
        S_FINAL    = 12'b0001_0000_0000,
        S_UPD_X    = 12'b0010_0000_0000,
        S_UPD_Y    = 12'b0100_0000_0000,
        S_OUT      = 12'b1000_0000_0000
    } state_t;

endpackage

`default_nettype wire

[design/rrbct_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/rrbct_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// avg + trunc((v - avg) / (k + 1)), one quotient bit per cycle
module rrbct_div #(
    parameter int WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [WIDTH-1:0]              avg,
    input  logic [WIDTH-1:0]              v,
    input  logic [rrbct_pkg::CNT_BITS-1:0] k,
    output logic                          busy,
    output logic                          done,
    output logic [WIDTH-1:0]              res
);

    localparam int CB   = rrbct_pkg::CNT_BITS;
    localparam int CNTW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic [CB-1:0]    rem_reg, rem_next;
    logic [CB:0]      div_reg, div_next;
    logic             neg_reg, neg_next;
    logic [WIDTH-1:0] avg_reg, avg_next;

    logic [WIDTH:0]   diff;
    logic [WIDTH:0]   diff_mag;
    logic [CB:0]      rem_sh;
    logic [CB:0]      rem_sub;
    logic             q_bit;

    always_comb
    begin
        diff     = {1'b0, v} - {1'b0, avg};
        diff_mag = diff[WIDTH] ? (~diff + 1'b1) : diff;
        rem_sh   = {rem_reg, q_reg[WIDTH-1]};
        q_bit    = (rem_sh >= div_reg);
        rem_sub  = rem_sh - div_reg;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        avg_next  = avg_reg;

        if (busy_reg)
        begin
            q_next   = {q_reg[WIDTH-2:0], q_bit};
            rem_next = q_bit ? rem_sub[CB-1:0] : rem_sh[CB-1:0];
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(WIDTH);
            q_next    = diff_mag[WIDTH-1:0];
            rem_next  = '0;
            div_next  = {1'b0, k} + (CB+1)'(1);
            neg_next  = diff[WIDTH];
            avg_next  = avg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        avg_reg <= avg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = neg_reg ? (avg_reg - q_reg) : (avg_reg + q_reg);

endmodule

`default_nettype wire

[design/row_run_blob_centroid_tracker_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// row-run blob centroid tracker: binary pixels come in one beat each, row by row; the
// running mean column and pixel count of the open run are kept, and a run closes after
// gap_limit off pixels or on the pixel at column line_width-1. a closed run is matched
// against the blob table (held in one ram, one slot per word) and yields one result beat:
// joined, new blob, or dropped when the table is full. all cumulative means go through a
// single shared restoring divider of width MW = max(COLUMN_BITS, ROW_BITS) + FRAC_BITS
// (16 by default) that produces one quotient bit per cycle. an on pixel waits for the
// divider to fold it into the run mean; when a pixel closes the run the blob walk follows:
// each occupied slot is read and checked, each merge runs an x and a y division and moves
// the later slots down, a joined blob runs an x and a y division, a new or dropped one
// goes straight to output, and the result waits while the previous beat is still held.
// the next pixel is taken while the previous result beat still waits at the output.
module row_run_blob_centroid_tracker_core #(
    parameter int BLOB_SLOTS  = 16,
    parameter int COLUMN_BITS = 11,
    parameter int ROW_BITS    = 12,
    parameter int FRAC_BITS   = 4
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // pixel channel
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      pixel_on,
    input  logic [COLUMN_BITS-1:0]                    column,
    input  logic [ROW_BITS-1:0]                       row,
    // result channel
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [1:0]                                status,
    output logic [$clog2(BLOB_SLOTS)-1:0]             blob_index,
    output logic [COLUMN_BITS+FRAC_BITS-1:0]          centroid_x,
    output logic [ROW_BITS+FRAC_BITS-1:0]             centroid_y,
    output logic [rrbct_pkg::CNT_BITS-1:0]            blob_height,
    output logic [$clog2(BLOB_SLOTS+1)-1:0]           blob_count,
    // configuration write channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [rrbct_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [rrbct_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    localparam int IW    = $clog2(BLOB_SLOTS);
    localparam int CW    = $clog2(BLOB_SLOTS + 1);
    localparam int XW    = COLUMN_BITS + FRAC_BITS;
    localparam int YW    = ROW_BITS + FRAC_BITS;
    localparam int MW    = (XW > YW) ? XW : YW;
    localparam int CB    = rrbct_pkg::CNT_BITS;
    localparam int GB    = rrbct_pkg::GAP_BITS;
    localparam int LB    = rrbct_pkg::LW_BITS;
    localparam int EW    = (COLUMN_BITS > LB) ? COLUMN_BITS : LB;
    localparam int OW    = ((COLUMN_BITS > CB) ? COLUMN_BITS : CB) + FRAC_BITS + 5;
    // slot word: mean x, mean y, last width, last row, rows
    localparam int REC_W = XW + YW + CB + ROW_BITS + CB;

    // configuration registers
    logic [GB-1:0] gap_limit_reg;
    logic [LB-1:0] line_width_reg;

    // control and working state
    rrbct_pkg::state_t  state_reg, state_next;
    rrbct_pkg::status_t status_reg, status_next;
    logic [XW-1:0]       run_mean_reg, run_mean_next;
    logic [CB-1:0]       run_pixels_reg, run_pixels_next;
    logic [GB-1:0]       gap_count_reg, gap_count_next;
    logic                run_open_reg, run_open_next;
    logic                close_reg, close_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                found_reg, found_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [XW-1:0]       wk_mx_reg, wk_mx_next;
    logic [YW-1:0]       wk_my_reg, wk_my_next;
    logic [CB-1:0]       wk_width_reg, wk_width_next;
    logic [CB-1:0]       wk_rows_reg, wk_rows_next;
    logic [YW-1:0]       oth_my_reg, oth_my_next;

    // output stage
    logic                out_valid_reg, out_valid_next;
    rrbct_pkg::status_t  out_status_reg, out_status_next;
    logic [IW-1:0]       out_index_reg, out_index_next;
    logic [XW-1:0]       out_cx_reg, out_cx_next;
    logic [YW-1:0]       out_cy_reg, out_cy_next;
    logic [CB-1:0]       out_ht_reg, out_ht_next;
    logic [CW-1:0]       out_count_reg, out_count_next;

    // shared divider
    logic          div_start, div_busy, div_done;
    logic [MW-1:0] div_avg, div_v, div_res;
    logic [CB-1:0] div_k;

    // slot ram
    logic             ram_we;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    logic [REC_W-1:0] ram_wdata, ram_rdata;

    // decoded read word
    logic [XW-1:0]       rd_mx;
    logic [YW-1:0]       rd_my;
    logic [CB-1:0]       rd_width;
    logic [ROW_BITS-1:0] rd_lastrow;
    logic [CB-1:0]       rd_rows;

    // pixel side helpers
    logic [LB-1:0] lw_m1;
    logic          row_end;
    logic [GB-1:0] gap_inc;
    logic [CB-1:0] pix_inc;
    logic [CB-1:0] rows_inc;
    logic [YW-1:0] row_fix;
    logic [CW-1:0] i_inc, j_inc;

    // overlap test in units of 2^-(FRAC_BITS+1) column, signed
    logic [OW-1:0] ov_rx, ov_rh, ov_g, ov_bx2, ov_bw, ov_gs;
    logic [OW-1:0] ov_hi, ov_lo, ov_left, ov_right, ov_dr;
    logic          ov_stale, ov_fail_lo, ov_fail_hi, ov_match;

    rrbct_div #(
        .WIDTH (MW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .avg   (div_avg),
        .v     (div_v),
        .k     (div_k),
        .busy  (div_busy),
        .done  (div_done),
        .res   (div_res)
    );

    rrbct_ram #(
        .WIDTH (REC_W),
        .DEPTH (BLOB_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_mx      = ram_rdata[REC_W-1 -: XW];
    assign rd_my      = ram_rdata[REC_W-XW-1 -: YW];
    assign rd_width   = ram_rdata[2*CB+ROW_BITS-1 -: CB];
    assign rd_lastrow = ram_rdata[CB+ROW_BITS-1 -: ROW_BITS];
    assign rd_rows    = ram_rdata[CB-1:0];

    // row end: only the last column of a non-zero line width
    assign lw_m1   = line_width_reg - LB'(1);
    assign row_end = (line_width_reg != '0) && (EW'(column) == EW'(lw_m1));

    assign gap_inc  = (gap_count_reg == rrbct_pkg::GAP_MAX) ? gap_count_reg
                                                            : gap_count_reg + GB'(1);
    assign pix_inc  = (run_pixels_reg == rrbct_pkg::CNT_MAX) ? run_pixels_reg
                                                             : run_pixels_reg + CB'(1);
    assign rows_inc = (wk_rows_reg == rrbct_pkg::CNT_MAX) ? wk_rows_reg
                                                          : wk_rows_reg + CB'(1);
    assign row_fix  = YW'(row_reg) << FRAC_BITS;
    assign i_inc    = i_reg + CW'(1);
    assign j_inc    = j_reg + CW'(1);

    always_comb
    begin
        ov_rx    = OW'(run_mean_reg[XW-1 -: COLUMN_BITS]);
        ov_rh    = OW'(run_pixels_reg[CB-1:1]);
        ov_g     = OW'(gap_limit_reg);
        ov_bx2   = OW'(rd_mx) << 1;
        ov_bw    = OW'(rd_width) << FRAC_BITS;
        ov_gs    = ov_g << (FRAC_BITS + 1);
        ov_hi    = (ov_rx + ov_rh + ov_g) << (FRAC_BITS + 1);
        ov_lo    = (ov_rx - ov_rh) << (FRAC_BITS + 1);
        ov_left  = ov_bx2 - ov_bw;
        ov_right = ov_bx2 + ov_bw + ov_gs;
        ov_dr    = OW'(row_reg) - OW'(rd_lastrow);
        // blob last seen more than gap_limit rows ago
        ov_stale   = $signed(ov_dr) > $signed(ov_g);
        ov_fail_lo = $signed(ov_hi) < $signed(ov_left);
        ov_fail_hi = $signed(ov_lo) > $signed(ov_right);
        ov_match   = !ov_stale && !ov_fail_lo && !ov_fail_hi;
    end

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        run_mean_next   = run_mean_reg;
        run_pixels_next = run_pixels_reg;
        gap_count_next  = gap_count_reg;
        run_open_next   = run_open_reg;
        close_next      = close_reg;
        row_next        = row_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        wk_mx_next      = wk_mx_reg;
        wk_my_next      = wk_my_reg;
        wk_width_next   = wk_width_reg;
        wk_rows_next    = wk_rows_reg;
        oth_my_next     = oth_my_reg;

        // output beat leaves when taken
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_cx_next     = out_cx_reg;
        out_cy_next     = out_cy_reg;
        out_ht_next     = out_ht_reg;
        out_count_next  = out_count_reg;

        in_ready  = 1'b0;
        div_start = 1'b0;
        div_avg   = MW'(wk_mx_reg);
        div_v     = MW'(run_mean_reg);
        div_k     = wk_width_reg;
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = {wk_mx_reg, wk_my_reg, run_pixels_reg, row_reg, wk_rows_reg};
        ram_raddr = i_reg[IW-1:0];

        unique case (state_reg)
            rrbct_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    row_next   = row;
                    i_next     = '0;
                    found_next = 1'b0;
                    if (pixel_on)
                    begin
                        // fold the pixel into the run mean
                        gap_count_next = '0;
                        run_open_next  = 1'b1;
                        close_next     = row_end;
                        div_start      = 1'b1;
                        div_avg        = MW'(run_mean_reg);
                        div_v          = MW'(XW'(column) << FRAC_BITS);
                        div_k          = run_pixels_reg;
                        state_next     = rrbct_pkg::S_RUNDIV;
                    end
                    else if (run_open_reg)
                    begin
                        gap_count_next = gap_inc;
                        if ((gap_inc >= gap_limit_reg) || row_end)
                        begin
                            state_next = rrbct_pkg::S_SCAN_RD;
                        end
                    end
                end
            end

            rrbct_pkg::S_RUNDIV:
            begin
                if (div_done)
                begin
                    run_mean_next   = div_res[XW-1:0];
                    run_pixels_next = pix_inc;
                    state_next      = close_reg ? rrbct_pkg::S_SCAN_RD : rrbct_pkg::S_IDLE;
                end
            end

            rrbct_pkg::S_SCAN_RD:
            begin
                ram_raddr  = i_reg[IW-1:0];
                state_next = (i_reg < count_reg) ? rrbct_pkg::S_SCAN_CHK
                                                 : rrbct_pkg::S_FINAL;
            end

            rrbct_pkg::S_SCAN_CHK:
            begin
                if (ov_match && !found_reg)
                begin
                    // first match takes the run
                    found_next    = 1'b1;
                    slot_next     = i_reg[IW-1:0];
                    wk_mx_next    = rd_mx;
                    wk_my_next    = rd_my;
                    wk_width_next = rd_width;
                    wk_rows_next  = rd_rows;
                    i_next        = i_inc;
                    state_next    = rrbct_pkg::S_SCAN_RD;
                end
                else if (ov_match)
                begin
                    // later match merges into the first one
                    oth_my_next = rd_my;
                    div_start   = 1'b1;
                    div_avg     = MW'(wk_mx_reg);
                    div_v       = MW'(rd_mx);
                    div_k       = rrbct_pkg::MERGE_K;
                    state_next  = rrbct_pkg::S_MERGE_X;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = rrbct_pkg::S_SCAN_RD;
                end
            end

            rrbct_pkg::S_MERGE_X:
            begin
                if (div_done)
                begin
                    wk_mx_next = div_res[XW-1:0];
                    div_start  = 1'b1;
                    div_avg    = MW'(wk_my_reg);
                    div_v      = MW'(oth_my_reg);
                    div_k      = rrbct_pkg::MERGE_K;
                    state_next = rrbct_pkg::S_MERGE_Y;
                end
            end

            rrbct_pkg::S_MERGE_Y:
            begin
                if (div_done)
                begin
                    wk_my_next = div_res[YW-1:0];
                    count_next = count_reg - CW'(1);
                    j_next     = i_reg;
                    state_next = rrbct_pkg::S_CMP_RD;
                end
            end

            rrbct_pkg::S_CMP_RD:
            begin
                // close the hole: slot j takes slot j+1
                ram_raddr = j_inc[IW-1:0];
                if (j_inc < count_reg + CW'(1) && j_reg < count_reg)
                begin
                    state_next = rrbct_pkg::S_CMP_WR;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = rrbct_pkg::S_SCAN_RD;
                end
            end

            rrbct_pkg::S_CMP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg[IW-1:0];
                ram_wdata  = ram_rdata;
                j_next     = j_inc;
                state_next = rrbct_pkg::S_CMP_RD;
            end

            rrbct_pkg::S_FINAL:
            begin
                if (found_reg)
                begin
                    status_next = rrbct_pkg::STATUS_JOIN;
                    div_start   = 1'b1;
                    div_avg     = MW'(wk_mx_reg);
                    div_v       = MW'(run_mean_reg);
                    div_k       = wk_width_reg;
                    state_next  = rrbct_pkg::S_UPD_X;
                end
                else if (count_reg >= CW'(BLOB_SLOTS))
                begin
                    status_next  = rrbct_pkg::STATUS_DROP;
                    slot_next    = '0;
                    wk_mx_next   = '0;
                    wk_my_next   = '0;
                    wk_rows_next = '0;
                    state_next   = rrbct_pkg::S_OUT;
                end
                else
                begin
                    // a fresh slot has zero weight, so its means become the run's
                    status_next  = rrbct_pkg::STATUS_NEW;
                    slot_next    = count_reg[IW-1:0];
                    wk_mx_next   = run_mean_reg;
                    wk_my_next   = row_fix;
                    wk_rows_next = CB'(1);
                    ram_we       = 1'b1;
                    ram_waddr    = count_reg[IW-1:0];
                    ram_wdata    = {run_mean_reg, row_fix, run_pixels_reg, row_reg, CB'(1)};
                    count_next   = count_reg + CW'(1);
                    state_next   = rrbct_pkg::S_OUT;
                end
            end

            rrbct_pkg::S_UPD_X:
            begin
                if (div_done)
                begin
                    wk_mx_next = div_res[XW-1:0];
                    div_start  = 1'b1;
                    div_avg    = MW'(wk_my_reg);
                    div_v      = MW'(row_fix);
                    div_k      = wk_rows_reg;
                    state_next = rrbct_pkg::S_UPD_Y;
                end
            end

            rrbct_pkg::S_UPD_Y:
            begin
                if (div_done)
                begin
                    wk_my_next   = div_res[YW-1:0];
                    wk_rows_next = rows_inc;
                    ram_we       = 1'b1;
                    ram_waddr    = slot_reg;
                    ram_wdata    = {wk_mx_reg, div_res[YW-1:0], run_pixels_reg, row_reg,
                                    rows_inc};
                    state_next   = rrbct_pkg::S_OUT;
                end
            end

            rrbct_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_index_next  = slot_reg;
                    out_cx_next     = wk_mx_reg;
                    out_cy_next     = wk_my_reg;
                    out_ht_next     = wk_rows_reg;
                    out_count_next  = count_reg;
                    run_mean_next   = '0;
                    run_pixels_next = '0;
                    gap_count_next  = '0;
                    run_open_next   = 1'b0;
                    state_next      = rrbct_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rrbct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrbct_pkg::S_IDLE;
            run_mean_reg   <= '0;
            run_pixels_reg <= '0;
            gap_count_reg  <= '0;
            run_open_reg   <= 1'b0;
            close_reg      <= 1'b0;
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_mean_reg   <= run_mean_next;
            run_pixels_reg <= run_pixels_next;
            gap_count_reg  <= gap_count_next;
            run_open_reg   <= run_open_next;
            close_reg      <= close_next;
            count_reg      <= count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        row_reg        <= row_next;
        slot_reg       <= slot_next;
        wk_mx_reg      <= wk_mx_next;
        wk_my_reg      <= wk_my_next;
        wk_width_reg   <= wk_width_next;
        wk_rows_reg    <= wk_rows_next;
        oth_my_reg     <= oth_my_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_cx_reg     <= out_cx_next;
        out_cy_reg     <= out_cy_next;
        out_ht_reg     <= out_ht_next;
        out_count_reg  <= out_count_next;
    end

    // configuration writes, unknown index ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg  <= rrbct_pkg::GAP_RESET;
            line_width_reg <= rrbct_pkg::LW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rrbct_pkg::REG_GAP_LIMIT:  gap_limit_reg  <= cfg_data[GB-1:0];
                rrbct_pkg::REG_LINE_WIDTH: line_width_reg <= cfg_data[LB-1:0];
                default:                   ;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign blob_index  = out_index_reg;
    assign centroid_x  = out_cx_reg;
    assign centroid_y  = out_cy_reg;
    assign blob_height = out_ht_reg;
    assign blob_count  = out_count_reg;

    // table never holds more blobs than slots
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BLOB_SLOTS))
        else $error("blob count beyond table size");

    // divider is never restarted mid-division
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // a finished result waits while the output beat is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrbct_pkg::S_OUT && out_valid_reg && !out_ready)
        |=> (state_reg == rrbct_pkg::S_OUT))
        else $error("result overwrote a pending beat");

    // an off pixel with no run open keeps the tracker idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !pixel_on && !run_open_reg)
        |=> (state_reg == rrbct_pkg::S_IDLE))
        else $error("idle off pixel left the idle state");

endmodule

`default_nettype wire
